// ===== design/ars_pkg.sv =====
package ars_pkg;

    localparam int OUT_RATE_DEF = 16000;
    localparam int RATE_W       = 17;
    localparam int SAMPLE_W     = 16;
    localparam int PHASE_W      = 17;
    localparam int FRAC_W       = 8;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = FIFO_PTR_W + 1;
    localparam int RESULTS_MAX  = 2;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // phase stage -> fraction stage
    typedef struct packed {
        logic                 valid;
        logic                 two;
        sample_t              prev;
        sample_t              cur;
        logic [PHASE_W-1:0]   p0;
        logic [PHASE_W-1:0]   p1;
    } ph_stage_t;

    // fraction stage -> interpolation/output queue
    typedef struct packed {
        logic                 valid;
        logic                 two;
        sample_t              prev;
        sample_t              cur;
        logic [FRAC_W-1:0]    f0;
        logic [FRAC_W-1:0]    f1;
    } fr_stage_t;

    typedef struct packed {
        sample_t              sample;
        logic                 last;
    } result_t;

endpackage

// ===== design/ars_if.sv =====
interface ars_in_if;
    import ars_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface ars_out_if;
    import ars_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    last_of_run;

    modport source (output valid, output sample_out, output last_of_run, input ready);
    modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

// ===== design/ars_phase_ctl.sv =====
module ars_phase_ctl #(
    parameter int OUT_RATE = ars_pkg::OUT_RATE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ars_pkg::RATE_W-1:0]    cfg_wdata,
    input  logic                          in_fire,
    input  ars_pkg::sample_t              sample_in,
    output ars_pkg::ph_stage_t            ph_out
);
    import ars_pkg::*;

    localparam logic [PHASE_W-1:0] OUT_P    = PHASE_W'(OUT_RATE);
    localparam logic [PHASE_W-1:0] MIN_STEP = PHASE_W'((OUT_RATE + 1) / 2);
    localparam logic [PHASE_W:0]   OUT_PX   = (PHASE_W + 1)'(OUT_RATE);

    logic [RATE_W-1:0]  rate_reg;
    logic [PHASE_W-1:0] phase_reg;
    sample_t            prev_reg;
    logic               have_prev_reg;
    sample_t            hold_reg;
    logic               pair_second_reg;
    ph_stage_t          ph_reg;

    logic [PHASE_W-1:0]  half_ext;
    logic                pair_mode;
    logic [SAMPLE_W:0]   pair_sum;
    sample_t             cur;
    logic [PHASE_W-1:0]  step;
    logic                stream_ok;
    logic [PHASE_W:0]    p1;
    logic [PHASE_W:0]    p2;
    logic                o0;
    logic                o1;
    logic [PHASE_W:0]    pe;
    logic [PHASE_W:0]    pw;
    logic [PHASE_W-1:0]  phase_next;

    always_comb
    begin
        half_ext  = {1'b0, rate_reg[RATE_W-1:1]};
        pair_mode = (half_ext >= OUT_P);
        pair_sum  = {hold_reg[SAMPLE_W-1], hold_reg} + {sample_in[SAMPLE_W-1], sample_in};
        cur       = pair_mode ? sample_t'(pair_sum[SAMPLE_W:1]) : sample_in;
        if (pair_mode)
            step = half_ext;
        else if (rate_reg < MIN_STEP)
            step = MIN_STEP;
        else
            step = rate_reg;
        stream_ok = !pair_mode || pair_second_reg;

        // at most two outputs: step is never below half the output rate
        p1 = {1'b0, phase_reg} + {1'b0, step};
        p2 = p1 + {1'b0, step};
        o0 = (phase_reg < OUT_P);
        o1 = o0 && (p1 < OUT_PX);
        if (o1)
            pe = p2;
        else if (o0)
            pe = p1;
        else
            pe = {1'b0, phase_reg};
        pw         = (pe >= OUT_PX) ? (pe - OUT_PX) : pe;
        phase_next = pw[PHASE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg        <= RATE_RESET;
            phase_reg       <= '0;
            prev_reg        <= '0;
            have_prev_reg   <= 1'b0;
            hold_reg        <= '0;
            pair_second_reg <= 1'b0;
            ph_reg          <= '0;
        end
        else if (cfg_we)
        begin
            rate_reg        <= cfg_wdata;
            phase_reg       <= '0;
            prev_reg        <= '0;
            have_prev_reg   <= 1'b0;
            hold_reg        <= '0;
            pair_second_reg <= 1'b0;
            ph_reg.valid    <= 1'b0;
        end
        else
        begin
            ph_reg.valid <= in_fire && stream_ok && have_prev_reg && o0;
            ph_reg.two   <= o1;
            ph_reg.prev  <= prev_reg;
            ph_reg.cur   <= cur;
            ph_reg.p0    <= phase_reg;
            ph_reg.p1    <= p1[PHASE_W-1:0];
            if (in_fire)
            begin
                if (!stream_ok)
                begin
                    hold_reg        <= sample_in;
                    pair_second_reg <= 1'b1;
                end
                else
                begin
                    pair_second_reg <= 1'b0;
                    prev_reg        <= cur;
                    have_prev_reg   <= 1'b1;
                    if (have_prev_reg)
                        phase_reg <= phase_next;
                end
            end
        end
    end

    assign ph_out = ph_reg;

endmodule

// ===== design/ars_frac_div.sv =====
module ars_frac_div #(
    parameter int OUT_RATE = ars_pkg::OUT_RATE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ars_pkg::ph_stage_t   ph_in,
    output ars_pkg::fr_stage_t   fr_out
);
    import ars_pkg::*;

    // floor(p * 2^FRAC_W / OUT_RATE) = (p * RECIP) >> RECIP_SH, exact for p < OUT_RATE
    localparam int                 RECIP_SH = 32;
    localparam int                 RECIP_W  = 28;
    localparam longint             RECIP_V  =
        ((longint'(1) << (RECIP_SH + FRAC_W)) + longint'(OUT_RATE) - 1) / longint'(OUT_RATE);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_V);
    localparam int                 PROD_W   = PHASE_W + RECIP_W;

    fr_stage_t fr_reg;

    function automatic logic [FRAC_W-1:0] frac_of(input logic [PHASE_W-1:0] p);
        logic [PROD_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, p} * {{PHASE_W{1'b0}}, RECIP};
        return prod[RECIP_SH +: FRAC_W];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_reg <= '0;
        else
        begin
            fr_reg.valid <= ph_in.valid;
            fr_reg.two   <= ph_in.two;
            fr_reg.prev  <= ph_in.prev;
            fr_reg.cur   <= ph_in.cur;
            fr_reg.f0    <= frac_of(ph_in.p0);
            fr_reg.f1    <= frac_of(ph_in.p1);
        end
    end

    assign fr_out = fr_reg;

endmodule

// ===== design/ars_out_fifo.sv =====
module ars_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ars_pkg::fr_stage_t             fr_in,
    input  logic                           pop,
    output logic                           not_empty,
    output ars_pkg::result_t               head,
    output logic [ars_pkg::FIFO_CNT_W-1:0] count
);
    import ars_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = FRAC_W + 1 + DIFF_W;

    result_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod0;
    logic signed [PROD_W-1:0] prod1;
    sample_t                  y0;
    sample_t                  y1;
    result_t                  r0;
    result_t                  r1;
    logic [FIFO_CNT_W-1:0]    wr_n;
    logic [FIFO_CNT_W-1:0]    count_next;

    // prev + floor(f * (cur - prev) / 256)
    always_comb
    begin
        diff  = DIFF_W'(fr_in.cur) - DIFF_W'(fr_in.prev);
        prod0 = $signed({1'b0, fr_in.f0}) * diff;
        prod1 = $signed({1'b0, fr_in.f1}) * diff;
        y0    = fr_in.prev + sample_t'(prod0 >>> FRAC_W);
        y1    = fr_in.prev + sample_t'(prod1 >>> FRAC_W);
        r0.sample = y0;
        r0.last   = !fr_in.two;
        r1.sample = y1;
        r1.last   = 1'b1;
        if (!fr_in.valid)
            wr_n = '0;
        else if (fr_in.two)
            wr_n = FIFO_CNT_W'(RESULTS_MAX);
        else
            wr_n = FIFO_CNT_W'(1);
        count_next = count_reg + wr_n - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (fr_in.valid)
        begin
            mem[wr_ptr_reg] <= r0;
            if (fr_in.two)
                mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + wr_n[FIFO_PTR_W-1:0];
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== design/audio_resampler_to_16k_unit.sv =====
// channel   dir  payload                          transaction when
// --------  ---  -------------------------------  ------------------------
// in_ch     in   sample_in[15:0] signed           in_ch.valid & in_ch.ready
// out_ch    out  sample_out[15:0] signed,         out_ch.valid & out_ch.ready
//                last_of_run
// cfg       in   cfg_wdata[16:0] input_rate       cfg_we
//
// One input transaction a cycle when the output side keeps up; each one
// gives zero, one or two results, so the output port (one result a cycle)
// sets the sustained rate at low input rates, where inputs can give two results.
// Accepted inputs pass the phase and fraction registers into the queue.
// in_ch.ready drops when the 8-entry result queue cannot hold two results
// for every transaction still in flight; out_ch stalls only fill the queue.
// rst_n (async, active low) clears all state but the queue storage; rate resets to 44100.
module audio_resampler_to_16k_unit #(
    parameter int OUT_RATE = ars_pkg::OUT_RATE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ars_pkg::RATE_W-1:0]  cfg_wdata,
    ars_in_if.sink                      in_ch,
    ars_out_if.source                   out_ch
);
    import ars_pkg::*;

    localparam int CRED_W = FIFO_CNT_W + 1;

    ph_stage_t             ph;
    fr_stage_t             fr;
    result_t               head;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [CRED_W-1:0]     reserve;
    logic                  in_fire;
    logic                  pop;

    // Worst case every in-flight transaction plus the new one lands two
    // results in the queue.
    always_comb
    begin
        reserve = CRED_W'(q_count)
                + CRED_W'(RESULTS_MAX) * (CRED_W'(ph.valid) + CRED_W'(fr.valid) + CRED_W'(1));
    end

    assign in_ch.ready = (reserve <= CRED_W'(FIFO_DEPTH));
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign pop         = not_empty && out_ch.ready;

    // stage 1: pair averaging, phase accumulator, result count
    ars_phase_ctl #(
        .OUT_RATE (OUT_RATE)
    ) u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .sample_in (in_ch.sample_in),
        .ph_out    (ph)
    );

    // stage 2: 8-bit interpolation fractions for both possible results
    ars_frac_div #(
        .OUT_RATE (OUT_RATE)
    ) u_frac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ph_in  (ph),
        .fr_out (fr)
    );

    // stage 3: interpolation multiply, written into the result queue
    ars_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .fr_in     (fr),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .count     (q_count)
    );

    assign out_ch.valid       = not_empty;
    assign out_ch.sample_out  = head.sample;
    assign out_ch.last_of_run = head.last;

endmodule

// ===== design/ars_checker.sv =====
module ars_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input ars_pkg::sample_t        sample_out,
    input logic                    last_of_run
);
    logic in_acc;
    logic out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // nothing to show right after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // a non-final result is always followed by its partner
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !last_of_run |=> out_valid && last_of_run)
        else $error("first of two results not followed by the last one");

    // empty queue and no recent input: no result can appear
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_acc && $past(!in_acc) && $past(!in_acc, 2) && $past(!in_acc, 3)
        |=> !out_valid)
        else $error("result without a source transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last_of_run))
        else $error("stalled result changed");

endmodule

bind audio_resampler_to_16k_unit ars_checker u_ars_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sample_out  (out_ch.sample_out),
    .last_of_run (out_ch.last_of_run)
);
